>>> design/assert_macros.svh
// assertion helpers, empty when synthesising
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define PFD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define PFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");
`else
`define PFD_ASSERT(lbl, clk, rst_n, prop)
`define PFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> design/pfd_pkg.sv
package pfd_pkg;

  localparam int SideN   = 5;
  localparam int CellsN  = SideN * SideN;
  localparam int AlphaN  = 26;
  localparam int LetterW = 5;
  localparam int CellW   = $clog2(CellsN);
  localparam int CoordW  = $clog2(SideN);

  typedef logic [LetterW-1:0] letter_t;
  typedef logic [CellW-1:0]   cell_t;
  typedef logic [CoordW-1:0]  coord_t;

  localparam letter_t LetI = letter_t'(8);
  localparam letter_t LetJ = letter_t'(9);

  typedef enum logic [1:0] {
    MODE_NEW_KEY    = 2'd0,
    MODE_KEY_LETTER = 2'd1,
    MODE_FINISH     = 2'd2,
    MODE_DECRYPT    = 2'd3
  } mode_e;

  // write into both position copies and the square
  typedef struct packed {
    logic    en;
    letter_t ltr;
    cell_t   slot;
  } place_wr_t;

  typedef struct packed {
    logic   hit;
    coord_t row;
    coord_t col;
  } lane_res_t;

  function automatic coord_t cell_row(cell_t c);
    coord_t r;
    r = '0;
    for (int i = 1; i < SideN; i++) begin
      if (c >= cell_t'(i * SideN)) r = coord_t'(i);
    end
    return r;
  endfunction

  function automatic coord_t cell_col(cell_t c);
    cell_t base;
    base = cell_t'(cell_t'(cell_row(c)) * cell_t'(SideN));
    return coord_t'(c - base);
  endfunction

  function automatic coord_t prev_coord(coord_t x);
    return (x == '0) ? coord_t'(SideN - 1) : coord_t'(x - coord_t'(1));
  endfunction

  function automatic cell_t make_cell(coord_t r, coord_t k);
    return cell_t'(cell_t'(r) * cell_t'(SideN) + cell_t'(k));
  endfunction

endpackage

>>> design/playfair_digraph_decrypt.sv
// channel   direction  handshake             fields
// command   in         start_i / busy_o      mode_i, letter_first_i, letter_second_i
// result    out        valid_o (one cycle)   plain_first_o, plain_second_o, not_found_o
//
// new key and key letter act on their own transfer; a decrypt result strobes
// once its transfer has passed the registered position lookup and then the registered square read
// finish walks the alphabet, one letter a cycle, and stays busy until the last letter
// reset clears the seen flags, fill pointer and ready flag at once
// the result side cannot stall, so commands are held off only during finish
module playfair_digraph_decrypt (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [1:0]       mode_i,
  input  pfd_pkg::letter_t letter_first_i,
  input  pfd_pkg::letter_t letter_second_i,
  output logic             valid_o,
  output pfd_pkg::letter_t plain_first_o,
  output pfd_pkg::letter_t plain_second_o,
  output logic             not_found_o
);
  import pfd_pkg::*;

  `include "assert_macros.svh"

  logic [AlphaN-1:0] seen_q;
  cell_t             fp_q;
  logic              ready_q;
  logic              fill_q;
  letter_t           fill_idx_q;
  logic              dec_s1_q, rdy_s1_q;

  logic      accept;
  mode_e     mode;
  letter_t   key_ltr;
  logic      key_ok, fill_ok, fill_last, not_full;
  place_wr_t wr;
  lane_res_t res_a, res_b;

  assign busy_o    = fill_q;
  assign accept    = start_i && !busy_o;
  assign mode      = mode_e'(mode_i);
  assign not_full  = fp_q < cell_t'(CellsN);
  assign key_ltr   = (letter_first_i == LetJ) ? LetI : letter_first_i;
  assign key_ok    = accept && (mode == MODE_KEY_LETTER) && !ready_q &&
                     (letter_first_i < letter_t'(AlphaN)) && !seen_q[key_ltr] && not_full;
  assign fill_ok   = fill_q && (fill_idx_q != LetJ) && !seen_q[fill_idx_q] && not_full;
  assign fill_last = fill_idx_q == letter_t'(AlphaN - 1);

  always_comb begin
    wr.en   = fill_ok || key_ok;
    wr.ltr  = fill_q ? fill_idx_q : key_ltr;
    wr.slot = fp_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= '0;
      fp_q       <= '0;
      ready_q    <= 1'b0;
      fill_q     <= 1'b0;
      fill_idx_q <= '0;
      dec_s1_q   <= 1'b0;
      rdy_s1_q   <= 1'b0;
    end else begin
      dec_s1_q <= accept && (mode == MODE_DECRYPT);
      rdy_s1_q <= ready_q;
      if (accept && (mode == MODE_NEW_KEY)) begin
        seen_q  <= '0;
        fp_q    <= '0;
        ready_q <= 1'b0;
      end else if (wr.en) begin
        seen_q[wr.ltr] <= 1'b1;
        fp_q           <= cell_t'(fp_q + cell_t'(1));
      end
      if (accept && (mode == MODE_FINISH)) begin
        fill_q     <= 1'b1;
        fill_idx_q <= '0;
      end else if (fill_q) begin
        fill_idx_q <= letter_t'(fill_idx_q + letter_t'(1));
        if (fill_last) begin
          fill_q  <= 1'b0;
          ready_q <= 1'b1;
        end
      end
    end
  end

  pfd_lane u_lane_a (
    .clk_i    (clk_i),
    .letter_i (letter_first_i),
    .seen_i   (seen_q),
    .wr_i     (wr),
    .res_o    (res_a)
  );

  pfd_lane u_lane_b (
    .clk_i    (clk_i),
    .letter_i (letter_second_i),
    .seen_i   (seen_q),
    .wr_i     (wr),
    .res_o    (res_b)
  );

  pfd_merge u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .dec_i          (dec_s1_q),
    .ready_i        (rdy_s1_q),
    .lane_a_i       (res_a),
    .lane_b_i       (res_b),
    .wr_i           (wr),
    .valid_o        (valid_o),
    .plain_first_o  (plain_first_o),
    .plain_second_o (plain_second_o),
    .not_found_o    (not_found_o)
  );

  `PFD_ASSERT(a_dec_result, clk_i, rst_ni, (accept && mode == MODE_DECRYPT) |-> ##2 valid_o)
  `PFD_ASSERT_IMP(a_result_cause, clk_i, rst_ni, valid_o, $past(accept && mode == MODE_DECRYPT, 2))
  `PFD_ASSERT_IMP(a_finish_ready, clk_i, rst_ni, $fell(busy_o), ready_q)
  `PFD_ASSERT_IMP(a_no_overfill, clk_i, rst_ni, wr.en, fp_q < cell_t'(CellsN))

endmodule

>>> design/pfd_lane.sv
module pfd_lane (
  input  logic                    clk_i,
  input  pfd_pkg::letter_t        letter_i,
  input  logic [pfd_pkg::AlphaN-1:0] seen_i,
  input  pfd_pkg::place_wr_t      wr_i,
  output pfd_pkg::lane_res_t      res_o
);
  import pfd_pkg::*;

  localparam int PadW = (2 ** LetterW) - AlphaN;

  cell_t                 pos_mem [AlphaN];
  cell_t                 pos_q;
  logic                  hit_q;
  logic [2**LetterW-1:0] seen_ext;

  assign seen_ext = {{PadW{1'b0}}, seen_i};

  always_ff @(posedge clk_i) begin
    if (wr_i.en) pos_mem[wr_i.ltr] <= wr_i.slot;
    pos_q <= pos_mem[letter_i];
    hit_q <= seen_ext[letter_i];
  end

  always_comb begin
    res_o.hit = hit_q;
    res_o.row = cell_row(pos_q);
    res_o.col = cell_col(pos_q);
  end

endmodule

>>> design/pfd_merge.sv
module pfd_merge (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                dec_i,
  input  logic                ready_i,
  input  pfd_pkg::lane_res_t  lane_a_i,
  input  pfd_pkg::lane_res_t  lane_b_i,
  input  pfd_pkg::place_wr_t  wr_i,
  output logic                valid_o,
  output pfd_pkg::letter_t    plain_first_o,
  output pfd_pkg::letter_t    plain_second_o,
  output logic                not_found_o
);
  import pfd_pkg::*;

  letter_t sq_mem [CellsN];
  letter_t sq_a_q, sq_b_q;
  logic    nf_q, strobe_q;
  cell_t   cell_a, cell_b;
  logic    hit;

  assign hit = ready_i && lane_a_i.hit && lane_b_i.hit;

  always_comb begin
    priority if (lane_a_i.row == lane_b_i.row) begin
      cell_a = make_cell(lane_a_i.row, prev_coord(lane_a_i.col));
      cell_b = make_cell(lane_b_i.row, prev_coord(lane_b_i.col));
    end else if (lane_a_i.col == lane_b_i.col) begin
      cell_a = make_cell(prev_coord(lane_a_i.row), lane_a_i.col);
      cell_b = make_cell(prev_coord(lane_b_i.row), lane_b_i.col);
    end else begin
      cell_a = make_cell(lane_a_i.row, lane_b_i.col);
      cell_b = make_cell(lane_b_i.row, lane_a_i.col);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) sq_mem[wr_i.slot] <= wr_i.ltr;
    sq_a_q <= sq_mem[cell_a];
    sq_b_q <= sq_mem[cell_b];
    nf_q   <= !hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= dec_i;
    end
  end

  assign valid_o        = strobe_q;
  assign not_found_o    = nf_q;
  assign plain_first_o  = nf_q ? '0 : sq_a_q;
  assign plain_second_o = nf_q ? '0 : sq_b_q;

endmodule
